// ===== design/qsu_pkg.sv =====
// Shared types, result codes and defaults for the quoted string unescaper.
`timescale 1ns / 1ps

package qsu_pkg;

  // Default depth of the result queue; two slots must be free to take a request.
  localparam int unsigned RESQ_DEPTH_DEF = 4;

  // Reset value of the length limit register.
  localparam logic [7:0] LIMIT_RESET = 8'd254;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_NEWLINE   = 3'd2;
  localparam logic [2:0] ERR_END       = 3'd3;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [2:0] code;
    logic [7:0] len;
    logic       last;
  } result_t;

  // Results produced by one accepted request, r0 first.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== design/qsu_decode.sv =====
// Decoder state machine: parses one byte per request and produces up to two results.
`timescale 1ns / 1ps

module qsu_decode import qsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       eoi,
  output push_t      push
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Simple escape letters; bit 8 set means the byte is a known escape.
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      8'h74:    r = {1'b1, 8'h09};   // t
      8'h6E:    r = {1'b1, 8'h0A};   // n
      8'h62:    r = {1'b1, 8'h08};   // b
      8'h72:    r = {1'b1, 8'h0D};   // r
      8'h5C:    r = {1'b1, 8'h5C};   // backslash
      8'h66:    r = {1'b1, 8'h0C};   // f
      8'h27:    r = {1'b1, 8'h27};   // single quote
      8'h22:    r = {1'b1, 8'h22};   // double quote
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic [8:0] oval_r, oval_nxt;
  logic [1:0] odig_r, odig_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] limit_r;

  logic [7:0] lim;
  logic       is_oct;
  logic [8:0] esc;
  logic       st_a, st_b, sb_pend, sb_en;
  logic [7:0] st_a_ch;
  logic [8:0] cnt9;
  logic       va, vb;
  result_t    res_a, res_b;

  // A limit of zero behaves as one.
  assign lim    = (limit_r == 8'd0) ? 8'd1 : limit_r;
  assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
  assign esc    = esc_map(in_byte);

  // Next state and results for the byte at the input, worked in model order.
  always_comb begin
    mode_nxt = mode_r;
    oval_nxt = oval_r;
    odig_nxt = odig_r;
    cnt_nxt  = cnt_r;
    st_a     = 1'b0;
    st_a_ch  = 8'd0;
    st_b     = 1'b0;
    sb_pend  = 1'b0;
    sb_en    = 1'b0;
    cnt9     = 9'd0;
    va       = 1'b0;
    vb       = 1'b0;
    res_a    = '0;
    res_b    = '0;

    // First action of the step.
    case (mode_r)
      MODE_IDLE: begin
        if (eoi) begin
          va = 1'b1;
          res_a.kind = KIND_ERR;
          res_a.code = ERR_END;
          oval_nxt = 9'd0;
          odig_nxt = 2'd0;
        end else if (in_byte == CH_QUOTE) begin
          mode_nxt = MODE_STR;
          cnt_nxt  = 8'd0;
          oval_nxt = 9'd0;
          odig_nxt = 2'd0;
        end else if (in_byte != CH_SPACE && in_byte != CH_TAB) begin
          va = 1'b1;
          res_a.kind = KIND_ERR;
          res_a.code = ERR_NO_QUOTE;
          oval_nxt = 9'd0;
          odig_nxt = 2'd0;
        end
      end
      MODE_STR: begin
        sb_pend = 1'b1;
      end
      MODE_ESC: begin
        if (eoi) begin
          va = 1'b1;
          res_a.kind = KIND_ERR;
          res_a.code = ERR_END;
          mode_nxt = MODE_IDLE;
          oval_nxt = 9'd0;
          odig_nxt = 2'd0;
        end else if (esc[8]) begin
          mode_nxt = MODE_STR;
          st_a     = 1'b1;
          st_a_ch  = esc[7:0];
        end else if (is_oct) begin
          mode_nxt = MODE_OCT;
          oval_nxt = {1'b0, in_byte - CH_ZERO};
          odig_nxt = 2'd1;
        end else begin
          va = 1'b1;
          res_a.kind = KIND_ERR;
          res_a.code = ERR_BAD_ESC;
          mode_nxt = MODE_IDLE;
          oval_nxt = 9'd0;
          odig_nxt = 2'd0;
        end
      end
      MODE_OCT: begin
        if (!eoi && is_oct) begin
          oval_nxt = {oval_r[5:0], 3'b000} + {6'd0, in_byte[2:0]};
          odig_nxt = odig_r + 2'd1;
          if (odig_nxt == 2'd3) begin
            mode_nxt = MODE_STR;
            odig_nxt = 2'd0;
            st_a     = 1'b1;
            st_a_ch  = oval_nxt[7:0];
          end
        end else begin
          // The pending octal character goes out, then the byte is string content.
          mode_nxt = MODE_STR;
          odig_nxt = 2'd0;
          st_a     = 1'b1;
          st_a_ch  = oval_r[7:0];
          sb_pend  = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    // Store of the first character, with the length check.
    if (st_a) begin
      cnt9    = {1'b0, cnt_nxt} + 9'd1;
      cnt_nxt = cnt9[7:0];
      va      = 1'b1;
      if (cnt9 >= {1'b0, lim}) begin
        res_a.kind = KIND_ERR;
        res_a.code = ERR_TOO_LONG;
        mode_nxt = MODE_IDLE;
        oval_nxt = 9'd0;
        odig_nxt = 2'd0;
      end else begin
        res_a.kind = KIND_CHAR;
        res_a.ch   = st_a_ch;
      end
    end

    // Plain string byte handling.
    sb_en = sb_pend && (mode_nxt == MODE_STR);
    if (sb_en) begin
      if (eoi) begin
        vb = 1'b1;
        res_b.kind = KIND_ERR;
        res_b.code = ERR_END;
        mode_nxt = MODE_IDLE;
        oval_nxt = 9'd0;
        odig_nxt = 2'd0;
      end else if (in_byte == CH_QUOTE) begin
        vb = 1'b1;
        res_b.kind = KIND_DONE;
        res_b.len  = cnt_nxt;
        mode_nxt = MODE_IDLE;
      end else if (in_byte == CH_NL) begin
        vb = 1'b1;
        res_b.kind = KIND_ERR;
        res_b.code = ERR_NEWLINE;
        mode_nxt = MODE_IDLE;
        oval_nxt = 9'd0;
        odig_nxt = 2'd0;
      end else if (in_byte == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        st_b = 1'b1;
      end
    end

    // Store of a plain character.
    if (st_b) begin
      cnt9    = {1'b0, cnt_nxt} + 9'd1;
      cnt_nxt = cnt9[7:0];
      vb      = 1'b1;
      if (cnt9 >= {1'b0, lim}) begin
        res_b.kind = KIND_ERR;
        res_b.code = ERR_TOO_LONG;
        mode_nxt = MODE_IDLE;
        oval_nxt = 9'd0;
        odig_nxt = 2'd0;
      end else begin
        res_b.kind = KIND_CHAR;
        res_b.ch   = in_byte;
      end
    end
  end

  // Pack results in order and mark the final one.
  always_comb begin
    push = '0;
    if (acc) begin
      if (va && vb) begin
        push.count   = 2'd2;
        push.r0      = res_a;
        push.r1      = res_b;
        push.r1.last = 1'b1;
      end else if (va) begin
        push.count   = 2'd1;
        push.r0      = res_a;
        push.r0.last = 1'b1;
      end else if (vb) begin
        push.count   = 2'd1;
        push.r0      = res_b;
        push.r0.last = 1'b1;
      end
    end
  end

  // Parser state and the length limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      oval_r  <= 9'd0;
      odig_r  <= 2'd0;
      cnt_r   <= 8'd0;
      limit_r <= LIMIT_RESET;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt;
        oval_r <= oval_nxt;
        odig_r <= odig_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== design/qsu_resq.sv =====
// Result queue: takes up to two results per cycle and hands out one per cycle while pop_ready is high.
`timescale 1ns / 1ps

module qsu_resq import qsu_pkg::*; #(
  parameter int unsigned DEPTH = RESQ_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop_ready,
  output result_t head,
  output logic    head_valid,
  output logic    space_ok
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_ROOM = CW'(DEPTH - 2);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  result_t       mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem[rp_r];
  assign space_ok   = (cnt_r <= CNT_ROOM);
  assign pop        = head_valid && pop_ready;
  assign wp1        = ptr_inc(wp_r);

  // Pointer and fill count updates.
  always_comb begin
    wp_nxt = wp_r;
    case (push.count)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = ptr_inc(wp1);
      default: wp_nxt = wp_r;
    endcase
    rp_nxt  = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wp1] <= push.r1;
    end
  end

endmodule

// ===== design/quoted_string_unescaper_core.sv =====
// Top level of the quoted string unescaper.
`timescale 1ns / 1ps

// Decodes a C-style double-quoted string literal from a byte stream, one byte
// per request and one request per cycle while in_tready is high. Spaces and
// tabs before the opening quote are skipped; each decoded character, the
// completion (with length) and any error come out as separate requests, at
// most two per input byte, the final one marked by out_tlast. With an empty
// queue the first result of a byte shows on the output in the cycle after the
// byte is accepted, and a second result once the first is taken. Results wait
// in a RESQ_DEPTH-entry queue, four by default; in_tready drops while fewer
// than two entries are free, so bytes are taken while earlier results wait.
// cfg_wr_data sets the character count at which a string fails as too long.
module quoted_string_unescaper_core import qsu_pkg::*; #(
  parameter int unsigned RESQ_DEPTH = RESQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_char, [10:8] error_code, [18:11] length
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

  logic    acc;
  push_t   push;
  result_t head;
  logic    space_ok;

  assign in_tready = space_ok;
  assign acc       = in_tvalid && space_ok;

  qsu_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .in_byte     (in_tdata),
    .eoi         (in_tlast),
    .push        (push)
  );

  qsu_resq #(
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .space_ok   (space_ok)
  );

  // Output packing.
  assign out_tdata = {5'd0, head.len, head.code, head.ch};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ===== design/qsu_checker.sv =====
// Port-level checks for the quoted string unescaper and their bind.
`timescale 1ns / 1ps

module qsu_checker import qsu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A completion or an error always ends the results of its byte.
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_CHAR |-> out_tlast)
    else $error("completion or error not marked last");

  // A character carries no error code and no length.
  a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_CHAR |-> out_tdata[18:8] == 11'd0)
    else $error("character result with stray fields");

  // An error carries a nonzero code and no character or length.
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERR
      |-> out_tdata[10:8] != ERR_NONE && out_tdata[7:0] == 8'd0
          && out_tdata[18:11] == 8'd0)
    else $error("malformed error result");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready
      |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind quoted_string_unescaper_core qsu_checker u_qsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/tb_quoted_string_unescaper_core.sv =====
// Self-checking testbench for the quoted string unescaper core.
`timescale 1ns / 1ps

module tb_quoted_string_unescaper_core;
  import qsu_pkg::*;

  // Byte values that steer the decoder.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [1:0] {
    LIT_IDLE,
    LIT_STRING,
    LIT_ESCAPE,
    LIT_OCTAL
  } lit_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Shadow copy of the decoder state and the length limit register.
  lit_mode_t   lit_mode = LIT_IDLE;
  logic [8:0]  oct_val = '0;
  logic [1:0]  oct_digits = '0;
  logic [8:0]  stored_chars = '0;
  logic [7:0]  limit_reg = LIMIT_RESET;

  result_t     step_results[$];
  result_t     decoded_queue[$];

  int          mismatches = 0;
  int          sent_requests = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;

  quoted_string_unescaper_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // A step never yields more than two results.
  function void add_result(logic [1:0] kind, logic [7:0] ch, logic [2:0] code,
                           logic [7:0] len);
    result_t r;
    r = '{kind: kind, ch: ch, code: code, len: len, last: 1'b0};
    if (step_results.size() < 2) step_results.push_back(r);
  endfunction

  function void abort_literal(logic [2:0] code);
    add_result(KIND_ERR, 8'd0, code, 8'd0);
    lit_mode   = LIT_IDLE;
    oct_val    = '0;
    oct_digits = '0;
  endfunction

  // Stores one decoded character unless it reaches the length limit.
  function void store_decoded(logic [7:0] c);
    logic [8:0] lim;
    lim = (limit_reg == 8'd0) ? 9'd1 : {1'b0, limit_reg};
    stored_chars = stored_chars + 9'd1;
    if (stored_chars >= lim) abort_literal(ERR_TOO_LONG);
    else add_result(KIND_CHAR, c, ERR_NONE, 8'd0);
  endfunction

  function void string_byte(logic [7:0] b, logic eoi);
    if (eoi) begin
      abort_literal(ERR_END);
    end else if (b == CH_QUOTE) begin
      add_result(KIND_DONE, 8'd0, ERR_NONE, stored_chars[7:0]);
      lit_mode = LIT_IDLE;
    end else if (b == CH_NL) begin
      abort_literal(ERR_NEWLINE);
    end else if (b == CH_BSLASH) begin
      lit_mode = LIT_ESCAPE;
    end else begin
      store_decoded(b);
    end
  endfunction

  function logic is_octal(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

  // Character for a single-letter escape; bit 8 set when the letter has none.
  function logic [8:0] escape_value(logic [7:0] b);
    case (b)
      8'h74:     return 9'h009;
      8'h6E:     return 9'h00A;
      8'h62:     return 9'h008;
      8'h72:     return 9'h00D;
      CH_BSLASH: return {1'b0, CH_BSLASH};
      8'h66:     return 9'h00C;
      CH_APOS:   return {1'b0, CH_APOS};
      CH_QUOTE:  return {1'b0, CH_QUOTE};
      default:   return 9'h100;
    endcase
  endfunction

  // Advances the shadow decoder by one accepted request and queues its results.
  function void decode_request(logic [7:0] b, logic eoi);
    logic [8:0] mapped;
    step_results.delete();
    case (lit_mode)
      LIT_IDLE: begin
        if (eoi) begin
          abort_literal(ERR_END);
        end else if (b == CH_QUOTE) begin
          lit_mode     = LIT_STRING;
          stored_chars = '0;
          oct_val      = '0;
          oct_digits   = '0;
        end else if (b != CH_SPACE && b != CH_TAB) begin
          abort_literal(ERR_NO_QUOTE);
        end
      end
      LIT_STRING: string_byte(b, eoi);
      LIT_ESCAPE: begin
        mapped = escape_value(b);
        if (eoi) begin
          abort_literal(ERR_END);
        end else if (!mapped[8]) begin
          lit_mode = LIT_STRING;
          store_decoded(mapped[7:0]);
        end else if (is_octal(b)) begin
          lit_mode   = LIT_OCTAL;
          oct_val    = {6'd0, b[2:0]};
          oct_digits = 2'd1;
        end else begin
          abort_literal(ERR_BAD_ESC);
        end
      end
      default: begin
        if (!eoi && is_octal(b)) begin
          oct_val    = {oct_val[5:0], b[2:0]};
          oct_digits = oct_digits + 2'd1;
          if (oct_digits == 2'd3) begin
            lit_mode   = LIT_STRING;
            oct_digits = '0;
            store_decoded(oct_val[7:0]);
          end
        end else begin
          // The pending octal character comes first, then the byte itself.
          lit_mode   = LIT_STRING;
          oct_digits = '0;
          store_decoded(oct_val[7:0]);
          if (lit_mode == LIT_STRING) string_byte(b, eoi);
        end
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) decoded_queue.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, ch: out_tdata[7:0], code: out_tdata[10:8],
              len: out_tdata[18:11], last: out_tlast};
      if (decoded_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0d char=%02h code=%0d len=%0d last=%0b",
                   $realtime, got.kind, got.ch, got.code, got.len, got.last);
      end else begin
        want = decoded_queue.pop_front();
        if (got !== want || out_tdata[23:19] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch: expected kind=%0d char=%02h code=%0d len=%0d last=%0b",
                     $realtime, want.kind, want.ch, want.code, want.len, want.last);
            $display("  got kind=%0d char=%02h code=%0d len=%0d last=%0b pad=%02h",
                     got.kind, got.ch, got.code, got.len, got.last, out_tdata[23:19]);
          end
        end
      end
    end
  end

  // Receiver readiness: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run when neither side moves a request for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_request(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_request(b, eoi);
    sent_requests++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (decoded_queue.size() > 0) @(negedge clk);
  endtask

  // The register is written only with no results outstanding.
  task automatic set_length_limit(input logic [7:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    limit_reg = value;
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // One literal with random content, mostly well formed.
  task automatic send_random_literal();
    int n;
    int pick;
    int digits;
    logic [7:0] escapes[8];
    escapes = '{8'h74, 8'h6E, 8'h62, 8'h72, CH_BSLASH, 8'h66, CH_APOS, CH_QUOTE};
    repeat ($urandom_range(2)) send_request($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
    send_request(CH_QUOTE, 1'b0);
    n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_request(8'($urandom_range(255)), 1'b0);
      end else if (pick < 60) begin
        send_request(CH_BSLASH, 1'b0);
        send_request(escapes[3'($urandom_range(7))], 1'b0);
      end else if (pick < 78) begin
        send_request(CH_BSLASH, 1'b0);
        digits = $urandom_range(1, 3);
        repeat (digits) send_request(CH_ZERO + 8'($urandom_range(7)), 1'b0);
      end else if (pick < 83) begin
        send_request(CH_BSLASH, 1'b0);
        send_request(8'($urandom_range(255)), 1'b0);
      end else begin
        send_request(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
      end
    end
    pick = $urandom_range(99);
    if (pick < 85) begin
      send_request(CH_QUOTE, 1'b0);
    end else if (pick < 90) begin
      send_request(8'($urandom_range(255)), 1'b1);
    end else if (pick < 95) begin
      send_request(CH_NL, 1'b0);
    end else begin
      send_request(CH_BSLASH, 1'b0);
      send_request(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Whitespace is skipped while idle; anything else or the end mark fails.
  task automatic test_idle_bytes();
    send_request(CH_SPACE, 1'b0);
    send_request(CH_TAB, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b1);
  endtask

  // Top byte value, a three-digit octal that overflows 8 bits, an octal
  // sequence cut short by the closing quote and one cut short by the end mark.
  task automatic test_octal_forms();
    send_request(CH_QUOTE, 1'b0);
    send_request(8'hFF, 1'b0);
    send_text("\\777\\1\"");
    send_text("\"\\4");
    send_request(8'h00, 1'b1);
  endtask

  // Bad escape letter, escaped newline, and a bare newline in the string.
  task automatic test_error_paths();
    send_text("\"\\q");
    send_request(CH_QUOTE, 1'b0);
    send_request(CH_BSLASH, 1'b0);
    send_request(CH_NL, 1'b0);
    send_request(CH_QUOTE, 1'b0);
    send_request(CH_NL, 1'b0);
  endtask

  // A zero limit acts as one; with a limit of two the octal character that
  // overflows drops the byte that ended it.
  task automatic test_length_limit();
    set_length_limit(8'd0);
    send_text("\"a");
    set_length_limit(8'd2);
    send_text("\"a\\5b");
  endtask

  // Longest accepted limit, crossed by a plain string; the limit is changed
  // while the string is open.
  task automatic test_long_string();
    logic [7:0] b;
    set_length_limit(8'd255);
    send_request(CH_QUOTE, 1'b0);
    repeat (120) begin
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE || b == CH_BSLASH || b == CH_NL) b = 8'h41;
      send_request(b, 1'b0);
    end
    set_length_limit(8'd200);
    set_length_limit(8'd255);
    repeat (140) begin
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE || b == CH_BSLASH || b == CH_NL) b = 8'h41;
      send_request(b, 1'b0);
    end
  endtask

  // The receiver holds off while requests keep coming, then the sender waits
  // for every result.
  task automatic test_backpressure();
    hold_cycles = 200;
    repeat (4) send_random_literal();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at;
    stop_at = sent_requests + count;
    while (sent_requests < stop_at) begin
      if ($urandom_range(99) < 12)
        send_request(8'($urandom_range(255)), 1'($urandom_range(1)));
      else send_random_literal();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 86;
    test_idle_bytes();
    test_octal_forms();
    test_error_paths();
    test_length_limit();
    test_long_string();
    test_backpressure();
    set_length_limit(8'd254);
    test_random_traffic(250);

    send_idle_pct = 86;
    recv_idle_pct = 35;
    set_length_limit(8'd6);
    test_random_traffic(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_length_limit(8'd1);
    test_random_traffic(40);
    set_length_limit(8'd20);
    test_random_traffic(140);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
